>>> design/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by sobel_fifo, sobel_grad and sobel_edge_threshold_top; no dependencies.
package sobel_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FIFO_DEPTH    = 8;

    // configuration register indexes
    localparam logic [1:0] IDX_WIDTH  = 2'd0;
    localparam logic [1:0] IDX_HEIGHT = 2'd1;
    localparam logic [1:0] IDX_THR    = 2'd2;

    localparam logic [11:0] RST_WIDTH  = 12'd640;
    localparam logic [15:0] RST_HEIGHT = 16'd480;
    localparam logic [10:0] RST_THR    = 11'd110;
    localparam logic [23:0] RST_T1SQ   = 24'((int'(RST_THR) + 1) * (int'(RST_THR) + 1));

    // gray = (R*COEF_R + G*COEF_G + B*COEF_B) >> 16, coefficients sum to 65536
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    typedef struct packed {
        logic        last;
        logic        is_edge;
        logic [15:0] y;
        logic [10:0] x;
    } res_t;

    typedef struct packed {
        logic emit;     // slot produces a result word
        logic pix;      // slot carries a pixel: touch line store and window
        logic edge_en;  // interior pixel: run the threshold test
        res_t res;
    } tag_t;

endpackage

>>> design/sobel_fifo.sv
// Output queue of result words for the Sobel edge threshold block.
// Depends on sobel_pkg (res_t).
module sobel_fifo import sobel_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_data,
    input  logic pop,
    output logic out_vld,
    output res_t out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    res_t            q_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            do_pop;

    assign out_vld  = (cnt_reg != '0);
    assign out_data = q_reg[rd_ptr_reg];
    assign do_pop   = pop && out_vld;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        cnt_next = cnt_reg + NW'(push) - NW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // the upstream reservation must never let the queue overflow
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg < NW'(DEPTH)) || do_pop)
        else $error("result queue overflow");

endmodule

>>> design/sobel_grad.sv
// Gray conversion, line store, 3x3 window, Sobel gradients and threshold test.
// Depends on sobel_pkg (tag_t, res_t, gray coefficients).
module sobel_grad import sobel_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_vld,
    input  tag_t          in_tag,
    input  logic [CW-1:0] in_addr,
    input  logic [23:0]   in_rgb,     // red [7:0], green [15:8], blue [23:16]
    input  logic          win_clr,
    input  logic [23:0]   t1sq,
    output logic          out_vld,
    output res_t          out_res
);

    // line store: {row r-2, row r-1} gray per column
    logic [15:0]        line_mem [MAX_WIDTH];
    logic [15:0]        line_rd_reg;

    // stage 1: products
    logic               s1_vld_reg;
    tag_t               s1_tag_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic [23:0]        pr_reg, pg_reg, pb_reg;
    logic [23:0]        gray_sum;
    logic               rd_en;

    // stage 2: gray + line store data
    logic               s2_vld_reg;
    tag_t               s2_tag_reg;
    logic [CW-1:0]      s2_addr_reg;
    logic [7:0]         s2_gray_reg;
    logic               wr_en;
    logic [7:0]         win_reg [6];
    logic [7:0]         c0, c1, c2;
    logic signed [11:0] right_sum, left_sum, top_sum, bot_sum, gx, gy;

    // stage 3: gradients
    logic               s3_vld_reg;
    tag_t               s3_tag_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic signed [23:0] gx_sq, gy_sq;

    // stage 4: squares
    logic               s4_vld_reg;
    tag_t               s4_tag_reg;
    logic [19:0]        gx2_reg, gy2_reg;
    logic [20:0]        mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        s1_tag_reg  <= in_tag;
        s1_addr_reg <= in_addr;
        pr_reg      <= 24'(in_rgb[7:0])   * 24'(COEF_R);
        pg_reg      <= 24'(in_rgb[15:8])  * 24'(COEF_G);
        pb_reg      <= 24'(in_rgb[23:16]) * 24'(COEF_B);
    end

    assign gray_sum = pr_reg + pg_reg + pb_reg;
    assign rd_en    = s1_vld_reg && s1_tag_reg.pix;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            line_rd_reg <= line_mem[s1_addr_reg];
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        s2_tag_reg  <= s1_tag_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_gray_reg <= gray_sum[23:16];
    end

    assign wr_en = s2_vld_reg && s2_tag_reg.pix;
    assign c0    = line_rd_reg[15:8];
    assign c1    = line_rd_reg[7:0];
    assign c2    = s2_gray_reg;

    // age the column: row r-1 moves to r-2, new gray becomes r-1
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[s2_addr_reg] <= {c1, c2};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || win_clr) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (wr_en) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= c0;
            win_reg[4] <= c1;
            win_reg[5] <= c2;
        end
    end

    // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1, c0..c2 column c
    assign right_sum = 12'(c0) + (12'(c1) << 1) + 12'(c2);
    assign left_sum  = 12'(win_reg[0]) + (12'(win_reg[1]) << 1) + 12'(win_reg[2]);
    assign top_sum   = 12'(win_reg[0]) + (12'(win_reg[3]) << 1) + 12'(c0);
    assign bot_sum   = 12'(win_reg[2]) + (12'(win_reg[5]) << 1) + 12'(c2);
    assign gx        = right_sum - left_sum;
    assign gy        = top_sum - bot_sum;

    // stage 3
    always_ff @(posedge aclk) begin
        s3_tag_reg <= s2_tag_reg;
        gx_reg     <= gx;
        gy_reg     <= gy;
    end

    assign gx_sq = 24'(gx_reg) * 24'(gx_reg);
    assign gy_sq = 24'(gy_reg) * 24'(gy_reg);

    // stage 4
    always_ff @(posedge aclk) begin
        s4_tag_reg <= s3_tag_reg;
        gx2_reg    <= gx_sq[19:0];
        gy2_reg    <= gy_sq[19:0];
    end

    assign mag     = 21'(gx2_reg) + 21'(gy2_reg);
    assign out_vld = s4_vld_reg && s4_tag_reg.emit;

    always_comb begin
        out_res         = s4_tag_reg.res;
        out_res.is_edge = s4_tag_reg.edge_en && (24'(mag) >= t1sq);
    end

    // line store reads and writes in flight always hit different columns
    a_addr_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (s1_addr_reg != s2_addr_reg))
        else $error("line store read and write collide");

    a_wr_follows_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> $past(rd_en))
        else $error("line store write without matching read");

endmodule

>>> design/sobel_edge_threshold_top.sv
// Sobel 3x3 edge detector with magnitude threshold, streaming RGB in, edge map out.
// Depends on sobel_pkg, sobel_grad and sobel_fifo.
//
// Pixels enter in raster order, one word per clock while s_tready is high; results
// come out one row and one column behind and the bottom row is pushed out by flush
// ticks (tuser high). The block takes one word per clock while the queue has room,
// except right after the last pixel of every row from the second row on, when it
// takes no word while it queues the right-border result. Flush ticks go at one per
// clock while the queue has room. The rate is set by the single-ported result path
// (one word per clock) into an 8-word output queue; an input word is only taken while
// the queue has room reserved for the up to two results it causes. A result passes
// the products, gray and line-store read, gradients and squares registers on its way
// to the queue, and the compare sits on the queue write. State sits in one MAX_WIDTH
// x 16 line store (read and written once per pixel) and a six-byte window. A
// configuration write to the width, height or threshold index restarts the frame.
module sobel_edge_threshold_top import sobel_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tuser,    // action: 0 pixel, 1 flush tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_x [10:0], out_y [26:11], is_edge [27], zero [31:28]
    output logic        m_tlast,    // frame_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RCW = $clog2(FIFO_DEPTH + 1);

    function automatic logic [CW-1:0] wm1_of(input logic [11:0] w);
        if (w < 12'd3) begin
            return CW'(2);
        end else if (int'(w) > MAX_WIDTH) begin
            return CW'(MAX_WIDTH - 1);
        end else begin
            return CW'(w - 12'd1);
        end
    endfunction

    function automatic logic [15:0] hm1_of(input logic [15:0] h);
        if (h < 16'd3) begin
            return 16'd2;
        end else begin
            return h - 16'd1;
        end
    endfunction

    logic [CW-1:0]  wm1_reg;
    logic [15:0]    hm1_reg;
    logic [23:0]    t1sq_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [15:0]    row_reg, row_next;
    logic [CW-1:0]  fl_reg, fl_next;
    logic           xtra_reg;
    logic [15:0]    xtra_y_reg;
    logic [RCW-1:0] res_cnt_reg, res_cnt_next;

    logic           cfg_valid;
    logic [11:0]    t1;
    logic           acc, pix_ok, fl_ok, take_pix, take_fl;
    logic           r_ge1, r_ge2, c_ge1, c_ge2, c_end, fl_end;
    logic           n1, n2, pop;
    logic           tag_vld;
    tag_t           tag;
    logic           q_push;
    res_t           q_in, q_out;

    assign cfg_valid = cfg_we &&
        (cfg_index == IDX_WIDTH || cfg_index == IDX_HEIGHT || cfg_index == IDX_THR);
    assign t1 = {1'b0, cfg_wdata[10:0]} + 12'd1;

    assign s_tready = !xtra_reg && (res_cnt_reg <= RCW'(FIFO_DEPTH - 2));
    assign acc      = s_tvalid && s_tready;
    assign pix_ok   = (row_reg <= hm1_reg);
    assign fl_ok    = (row_reg > hm1_reg);
    assign take_pix = acc && !s_tuser && pix_ok;
    assign take_fl  = acc && s_tuser && fl_ok;

    assign r_ge1  = (row_reg != '0);
    assign r_ge2  = (row_reg >= 16'd2);
    assign c_ge1  = (col_reg != '0);
    assign c_ge2  = (col_reg >= CW'(2));
    assign c_end  = (col_reg == wm1_reg);
    assign fl_end = (fl_reg >= wm1_reg);

    assign n1  = take_pix && r_ge1 && c_ge1;
    assign n2  = take_pix && r_ge1 && c_end;
    assign pop = m_tvalid && m_tready;

    // reserve queue room at accept, release on each word taken
    assign res_cnt_next = res_cnt_reg + RCW'(n1) + RCW'(n2) + RCW'(take_fl) - RCW'(pop);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        fl_next  = fl_reg;
        if (take_pix) begin
            if (c_end) begin
                col_next = '0;
                row_next = row_reg + 16'd1;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        if (take_fl) begin
            if (fl_end) begin
                col_next = '0;
                row_next = '0;
                fl_next  = '0;
            end else begin
                fl_next = fl_reg + CW'(1);
            end
        end
    end

    // slot handed to the datapath: right-border result, pixel or flush tick
    always_comb begin
        tag     = '0;
        tag_vld = 1'b0;
        if (xtra_reg) begin
            tag_vld      = 1'b1;
            tag.emit     = 1'b1;
            tag.res.x    = 11'(wm1_reg);
            tag.res.y    = xtra_y_reg;
        end else if (take_pix) begin
            tag_vld      = 1'b1;
            tag.pix      = 1'b1;
            tag.emit     = n1;
            tag.edge_en  = r_ge2 && c_ge2;
            tag.res.x    = 11'(col_reg - CW'(1));
            tag.res.y    = row_reg - 16'd1;
        end else if (take_fl) begin
            tag_vld      = 1'b1;
            tag.emit     = 1'b1;
            tag.res.x    = 11'(fl_reg);
            tag.res.y    = hm1_reg;
            tag.res.last = fl_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg     <= wm1_of(RST_WIDTH);
            hm1_reg     <= hm1_of(RST_HEIGHT);
            t1sq_reg    <= RST_T1SQ;
            col_reg     <= '0;
            row_reg     <= '0;
            fl_reg      <= '0;
            xtra_reg    <= 1'b0;
            res_cnt_reg <= '0;
        end else begin
            res_cnt_reg <= res_cnt_next;
            if (cfg_valid) begin
                case (cfg_index)
                    IDX_WIDTH:  wm1_reg  <= wm1_of(cfg_wdata[11:0]);
                    IDX_HEIGHT: hm1_reg  <= hm1_of(cfg_wdata);
                    IDX_THR:    t1sq_reg <= 24'(t1) * 24'(t1);
                    default: ;
                endcase
                col_reg  <= '0;
                row_reg  <= '0;
                fl_reg   <= '0;
                xtra_reg <= 1'b0;
            end else begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                fl_reg   <= fl_next;
                xtra_reg <= n2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (n2) begin
            xtra_y_reg <= row_reg - 16'd1;
        end
    end

    sobel_grad #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_grad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (tag_vld),
        .in_tag   (tag),
        .in_addr  (col_reg),
        .in_rgb   (s_tdata),
        .win_clr  (cfg_valid),
        .t1sq     (t1sq_reg),
        .out_vld  (q_push),
        .out_res  (q_in)
    );

    sobel_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (pop),
        .out_vld   (m_tvalid),
        .out_data  (q_out)
    );

    assign m_tdata = {4'b0, q_out.is_edge, q_out.y, q_out.x};
    assign m_tlast = q_out.last;

    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RCW'(FIFO_DEPTH))
        else $error("result reservation exceeds queue depth");

    a_xtra_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (n2 && !cfg_valid) |=> (!s_tready && tag_vld && tag.emit && !tag.pix))
        else $error("right-border slot missing after row end");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_fl && fl_end) |=> (row_reg == '0 && col_reg == '0 && fl_reg == '0))
        else $error("counters not cleared at frame end");

endmodule

>>> verif/tb_sobel_edge_threshold_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_threshold_top: streams RGB frames and flush ticks,
// predicts every edge-map word and compares it field by field at the result port.
// Depends on sobel_pkg and the design files under design/.
module tb_sobel_edge_threshold_top;
    import sobel_pkg::*;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_WORDS  = 450;
    localparam logic [1:0]  IDX_NONE      = 2'd3;
    localparam logic [23:0] RGB_BLACK     = 24'h000000;
    localparam logic [23:0] RGB_WHITE     = 24'hFFFFFF;
    localparam logic [23:0] RGB_RED       = 24'h0000FF;

    // idle patterns for both sides
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_SPARSE = 2;

    typedef struct {
        bit          flush;
        logic [23:0] rgb;
        int          gap;
        bit          drain_first;
    } pixel_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    pixel_word_t pending_words[$];
    pixel_word_t cur_word;
    res_t        edge_results_due[$];
    int          idle_count     = 0;
    int          rx_stall       = 0;
    int          rx_mode        = IDLE_NONE;
    logic        rx_hold        = 1'b0;
    bit          hold_go        = 1'b0;
    int          mismatch_count = 0;
    int          counted_words  = 0;
    int          cycle_count    = 0;

    // predictor state
    logic [11:0] frame_width_reg;
    logic [15:0] frame_height_reg;
    logic [10:0] edge_thr_reg;
    logic [7:0]  luma_two_up [MAX_WIDTH_DEF];
    logic [7:0]  luma_one_up [MAX_WIDTH_DEF];
    logic [7:0]  luma_window [6];
    int          pixel_col;
    int          pixel_row;
    int          flush_col;

    sobel_edge_threshold_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int active_width();
        int w;
        w = frame_width_reg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = frame_height_reg;
        if (h < 3) h = 3;
        return h;
    endfunction

    function automatic void restart_frame();
        pixel_col = 0;
        pixel_row = 0;
        flush_col = 0;
        for (int i = 0; i < 6; i++) luma_window[i] = '0;
    endfunction

    function automatic void predict_edge_results(input bit flush, input logic [7:0] red,
                                                 input logic [7:0] green,
                                                 input logic [7:0] blue);
        int   w, h, c, r, gray, thr1, mag;
        int   c0, c1, c2, a0, a1, a2, b0, b2, gx, gy;
        res_t res;
        w = active_width();
        h = active_height();
        if (flush) begin
            // ticks before the bottom row is in are dropped
            if (pixel_row < h) return;
            res.x       = 11'(flush_col);
            res.y       = 16'(h - 1);
            res.is_edge = 1'b0;
            res.last    = (flush_col >= w - 1);
            edge_results_due.push_back(res);
            flush_col++;
            if (res.last) restart_frame();
            return;
        end
        if (pixel_row >= h) return;
        gray = (int'(COEF_R) * int'(red) + int'(COEF_G) * int'(green)
                + int'(COEF_B) * int'(blue)) >> 16;
        c  = pixel_col;
        r  = pixel_row;
        c0 = luma_two_up[c];
        c1 = luma_one_up[c];
        c2 = gray;
        a0 = luma_window[0];
        a1 = luma_window[1];
        a2 = luma_window[2];
        b0 = luma_window[3];
        b2 = luma_window[5];
        gx = (c0 + 2 * c1 + c2) - (a0 + 2 * a1 + a2);
        gy = (a0 + 2 * b0 + c0) - (a2 + 2 * b2 + c2);
        if (r >= 1 && c >= 1) begin
            res.x       = 11'(c - 1);
            res.y       = 16'(r - 1);
            res.is_edge = 1'b0;
            res.last    = 1'b0;
            if (r >= 2 && c >= 2) begin
                mag  = gx * gx + gy * gy;
                thr1 = int'(edge_thr_reg) + 1;
                res.is_edge = (mag >= thr1 * thr1);
            end
            edge_results_due.push_back(res);
        end
        // right border result trails the last pixel of the row
        if (r >= 1 && c >= w - 1) begin
            res.x       = 11'(w - 1);
            res.y       = 16'(r - 1);
            res.is_edge = 1'b0;
            res.last    = 1'b0;
            edge_results_due.push_back(res);
        end
        luma_two_up[c] = luma_one_up[c];
        luma_one_up[c] = 8'(gray);
        luma_window[0] = luma_window[3];
        luma_window[1] = luma_window[4];
        luma_window[2] = luma_window[5];
        luma_window[3] = 8'(c0);
        luma_window[4] = 8'(c1);
        luma_window[5] = 8'(c2);
        if (c >= w - 1) begin
            pixel_col = 0;
            pixel_row = r + 1;
        end else begin
            pixel_col = c + 1;
        end
    endfunction

    function automatic int draw_idle(input int mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_RANDOM: return $urandom_range(0, 14);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    function automatic logic [23:0] pick_rgb(input int pattern, input int x, input int y,
                                             input int split, input logic [23:0] dark,
                                             input logic [23:0] bright);
        case (pattern)
            0:       return 24'($urandom);
            1:       return (x >= split) ? bright : dark;
            2:       return (x + y >= split) ? bright : dark;
            default: return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                             ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                             ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t: %s", $time, msg);
    endtask

    task automatic queue_word(input bit flush, input logic [23:0] rgb, input int gap_mode,
                              input bit drain = 1'b0);
        pixel_word_t word;
        word.flush       = flush;
        word.rgb         = rgb;
        word.gap         = draw_idle(gap_mode);
        word.drain_first = drain || ($urandom_range(0, 299) == 0);
        pending_words.push_back(word);
    endtask

    // One frame in raster order plus its flush ticks, with stray words mixed in.
    // A non-negative stop_after cuts the frame short and skips the flush.
    task automatic queue_frame(input int wide, input int tall, input int gap_mode,
                               input int stop_after);
        int          pattern, split, n;
        logic [23:0] dark, bright;
        pattern = $urandom_range(0, 3);
        split   = $urandom_range(0, wide + tall);
        dark    = 24'($urandom);
        bright  = 24'($urandom);
        n       = 0;
        for (int y = 0; y < tall && n != stop_after; y++) begin
            for (int x = 0; x < wide && n != stop_after; x++) begin
                if ($urandom_range(0, 39) == 0) queue_word(1'b1, 24'($urandom), gap_mode);
                queue_word(1'b0, pick_rgb(pattern, x, y, split, dark, bright), gap_mode);
                n++;
            end
        end
        counted_words += n;
        if (n != stop_after) begin
            for (int x = 0; x < wide; x++) begin
                if ($urandom_range(0, 11) == 0) queue_word(1'b0, 24'($urandom), gap_mode);
                queue_word(1'b1, 24'($urandom), gap_mode);
            end
            counted_words += wide;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            IDX_WIDTH: begin
                frame_width_reg = value[11:0];
                restart_frame();
            end
            IDX_HEIGHT: begin
                frame_height_reg = value;
                restart_frame();
            end
            IDX_THR: begin
                edge_thr_reg = value[10:0];
                restart_frame();
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_and_settle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || edge_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin : drive_words
        bit offer;
        offer = s_tvalid;
        if (s_tvalid && s_tready) begin
            predict_edge_results(cur_word.flush, cur_word.rgb[7:0], cur_word.rgb[15:8],
                                 cur_word.rgb[23:16]);
            offer = 1'b0;
        end
        if (aresetn && !offer && pending_words.size() != 0) begin
            // hold a drain-first word until the output side has caught up
            if (pending_words[0].drain_first && edge_results_due.size() != 0) begin
                idle_count = 0;
            end else if (idle_count >= pending_words[0].gap) begin
                cur_word   = pending_words.pop_front();
                idle_count = 0;
                offer      = 1'b1;
                s_tdata   <= cur_word.rgb;
                s_tuser   <= cur_word.flush;
            end else begin
                idle_count++;
            end
        end
        s_tvalid <= offer;
    end

    always @(posedge aclk) begin : check_results
        res_t want;
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (edge_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word x=%0d y=%0d",
                                              m_tdata[10:0], m_tdata[26:11]));
                end else begin
                    want = edge_results_due.pop_front();
                    if (m_tdata[10:0] !== want.x)
                        report_mismatch($sformatf("out_x got %0d want %0d (y %0d)",
                                                  m_tdata[10:0], want.x, want.y));
                    if (m_tdata[26:11] !== want.y)
                        report_mismatch($sformatf("out_y got %0d want %0d (x %0d)",
                                                  m_tdata[26:11], want.y, want.x));
                    if (m_tdata[27] !== want.is_edge)
                        report_mismatch($sformatf("is_edge got %0d want %0d at (%0d,%0d)",
                                                  m_tdata[27], want.is_edge, want.x, want.y));
                    if (m_tdata[31:28] !== 4'd0)
                        report_mismatch($sformatf("pad bits got %0h at (%0d,%0d)",
                                                  m_tdata[31:28], want.x, want.y));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("frame_last got %0d want %0d at (%0d,%0d)",
                                                  m_tlast, want.last, want.x, want.y));
                end
                rx_stall = draw_idle(rx_mode);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_tready <= !rx_hold && rx_stall == 0;
        end
    end

    // long output stall while the sender keeps pushing
    initial begin : rx_hold_off
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sobel_edge_threshold_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int pattern, split, gap_mode, w_raw, h_raw, thr, wide, tall, frames, stop, goal;
        logic [23:0] dark, bright;

        frame_width_reg  = RST_WIDTH;
        frame_height_reg = RST_HEIGHT;
        edge_thr_reg     = RST_THR;
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            luma_two_up[i] = '0;
            luma_one_up[i] = '0;
        end
        restart_frame();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: one row and a bit of 640 wide
        rx_mode = IDLE_RANDOM;
        for (int i = 0; i < 660; i++) begin
            if (i % 150 == 0) begin
                pattern  = $urandom_range(0, 3);
                split    = $urandom_range(0, 700);
                dark     = 24'($urandom);
                bright   = 24'($urandom);
                gap_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            end
            queue_word(1'b0, pick_rgb(pattern, i % 640, i / 640, split, dark, bright), gap_mode);
        end
        drain_and_settle();

        // directed: clamped 3x3 geometry, zero threshold, stray words
        write_reg(IDX_WIDTH, 16'hF001);
        write_reg(IDX_HEIGHT, 16'h0000);
        write_reg(IDX_THR, 16'hF800);
        write_reg(IDX_NONE, 16'hFFFF);
        rx_mode = IDLE_NONE;
        queue_word(1'b1, RGB_WHITE, IDLE_NONE);
        for (int y = 0; y < 3; y++) begin
            queue_word(1'b0, RGB_BLACK, IDLE_NONE);
            queue_word(1'b0, RGB_BLACK, IDLE_NONE);
            queue_word(1'b0, RGB_WHITE, IDLE_NONE);
        end
        queue_word(1'b1, RGB_BLACK, IDLE_NONE);
        queue_word(1'b0, RGB_WHITE, IDLE_NONE);
        queue_word(1'b1, RGB_BLACK, IDLE_NONE);
        queue_word(1'b1, RGB_BLACK, IDLE_NONE);
        queue_word(1'b0, RGB_RED, IDLE_RANDOM, 1'b1);
        for (int i = 0; i < 8; i++) queue_word(1'b0, RGB_RED, IDLE_RANDOM);
        for (int i = 0; i < 3; i++) queue_word(1'b1, RGB_WHITE, IDLE_RANDOM);
        drain_and_settle();

        // back-pressure: receiver stalls while the sender streams at full rate
        write_reg(IDX_WIDTH, 16'd8);
        write_reg(IDX_HEIGHT, 16'd6);
        write_reg(IDX_THR, 16'($urandom_range(0, 300)));
        rx_mode = IDLE_SPARSE;
        hold_go = 1'b1;
        queue_frame(8, 6, IDLE_NONE, -1);
        queue_frame(8, 6, IDLE_NONE, -1);
        drain_and_settle();

        // width register above the line store size, frame cut early
        write_reg(IDX_WIDTH, 16'h0FFF);
        write_reg(IDX_HEIGHT, 16'd3);
        write_reg(IDX_THR, 16'($urandom_range(50, 400)));
        rx_mode = IDLE_SPARSE;
        queue_frame(active_width(), 3, IDLE_NONE, 40);
        drain_and_settle();

        // tallest frame, cut after a few rows; top threshold
        write_reg(IDX_WIDTH, 16'd5);
        write_reg(IDX_HEIGHT, 16'hFFFF);
        write_reg(IDX_THR, 16'h07FF);
        rx_mode = IDLE_RANDOM;
        queue_frame(5, active_height(), IDLE_RANDOM, 20);
        queue_word(1'b1, 24'($urandom), IDLE_RANDOM);
        queue_word(1'b1, 24'($urandom), IDLE_RANDOM);
        drain_and_settle();

        goal = counted_words + RANDOM_WORDS;
        while (counted_words < goal) begin
            case ($urandom_range(0, 9))
                0:       w_raw = $urandom_range(0, 2);
                1:       w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 14))
                0:       h_raw = $urandom_range(0, 2);
                1:       h_raw = 65535;
                default: h_raw = $urandom_range(3, 6);
            endcase
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 2047;
                2:       thr = $urandom_range(0, 1443);
                default: thr = $urandom_range(0, 400);
            endcase
            write_reg(IDX_WIDTH, {4'($urandom), 12'(w_raw)});
            write_reg(IDX_HEIGHT, 16'(h_raw));
            write_reg(IDX_THR, {5'($urandom), 11'(thr)});
            if ($urandom_range(0, 3) == 0) write_reg(IDX_NONE, 16'($urandom));
            rx_mode  = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            gap_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            wide     = active_width();
            tall     = active_height();
            if (tall > 64) begin
                queue_frame(wide, tall, gap_mode, 4 * wide);
                queue_word(1'b1, 24'($urandom), gap_mode);
            end else begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    stop = -1;
                    if (f == frames - 1 && $urandom_range(0, 5) == 0)
                        stop = $urandom_range(1, wide * tall - 1);
                    queue_frame(wide, tall, gap_mode, stop);
                end
            end
            drain_and_settle();
        end

        if (mismatch_count == 0) begin
            $display("sobel_edge_threshold_top regression: pass");
        end else begin
            $display("sobel_edge_threshold_top regression: fail");
        end
        $finish;
    end

endmodule
